// ===== hdl/span_coverage_buffer_defines.svh =====
// assertion macros for the span coverage buffer
`ifndef SPAN_COVERAGE_BUFFER_DEFINES_SVH
`define SPAN_COVERAGE_BUFFER_DEFINES_SVH
`ifndef ASSERT_OFF
`define SCB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SCB_ASSERT(lbl, prop, msg)
`define SCB_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== hdl/scb_pkg.sv =====
// shared constants and types for the span coverage buffer
`timescale 1ns / 1ps
package scb_pkg;
  localparam int LINE_W          = 11;
  localparam int MAX_LINES_DEF   = 1024;
  localparam int MAX_SPANS_DEF   = 64;
  localparam int COORD_BITS_DEF  = 11;
  localparam logic [LINE_W-1:0] WIDTH_RST  = 11'd320;
  localparam logic [LINE_W-1:0] HEIGHT_RST = 11'd200;
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;
  localparam logic KIND_REOPEN = 1'b0;

  typedef struct packed {
    logic [LINE_W-1:0] screen_width;
    logic [LINE_W-1:0] screen_height;
  } cfg_t;
endpackage

// ===== hdl/scb_ram.sv =====
// simple dual-port synchronous ram with registered read
`timescale 1ns / 1ps
module scb_ram import scb_pkg::*; #(
  parameter int DW = 8,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);
  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== hdl/scb_cfg.sv =====
// configuration registers behind the apb port
`timescale 1ns / 1ps
module scb_cfg import scb_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.screen_width  <= WIDTH_RST;
      cfg_r.screen_height <= HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_WIDTH:  cfg_r.screen_width  <= pwdata[LINE_W-1:0];
        REG_HEIGHT: cfg_r.screen_height <= pwdata[LINE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WIDTH:  prdata = {{(32-LINE_W){1'b0}}, cfg_r.screen_width};
      REG_HEIGHT: prdata = {{(32-LINE_W){1'b0}}, cfg_r.screen_height};
      default:    prdata = '0;
    endcase
  end

  assign pready = 1'b1;
  assign cfg    = cfg_r;
endmodule

// ===== hdl/span_coverage_buffer.sv =====
// span coverage buffer: per-scanline open span lists in a ram, updated per word
// reset: a clearing pass writes zero counts to all MAX_LINES lines, no word taken
// reopen word: each line in use gets one span across the screen width, one line written per cycle
// rectangle word: per row the count is read, then each stored span is read and processed; a split
//   sends its right piece to the scratch row, and those pieces are copied back; span reads are registered ram reads
// one word is worked on at a time; the result sits in an output register
`timescale 1ns / 1ps
`include "span_coverage_buffer_defines.svh"
module span_coverage_buffer import scb_pkg::*; #(
  parameter int MAX_LINES  = MAX_LINES_DEF,
  parameter int MAX_SPANS  = MAX_SPANS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [LINE_W-1:0] in_rect_left,
  input  logic [LINE_W-1:0] in_rect_right,
  input  logic [LINE_W-1:0] in_rect_top,
  input  logic [LINE_W-1:0] in_rect_bottom,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [LINE_W-1:0] out_open_lines,
  output logic              out_all_covered,
  output logic              out_span_overflow,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam int CW    = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_SPANS + 1);
  localparam int IDX_W = $clog2(MAX_SPANS);
  localparam int ROW_W = $clog2(MAX_LINES + 1);
  localparam int LA_W  = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
  localparam int SA_W  = ROW_W + IDX_W;
  localparam int LCAP  = (MAX_LINES > 2047) ? 2047 : MAX_LINES;
  localparam logic [ROW_W-1:0] SCR_ROW = ROW_W'(MAX_LINES);

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b0000_0000_0001,
    S_IDLE     = 12'b0000_0000_0010,
    S_REOPEN   = 12'b0000_0000_0100,
    S_ROW_RD   = 12'b0000_0000_1000,
    S_ROW_WAIT = 12'b0000_0001_0000,
    S_SPAN_RD  = 12'b0000_0010_0000,
    S_SPAN_PRC = 12'b0000_0100_0000,
    S_SPLIT    = 12'b0000_1000_0000,
    S_COPY_RD  = 12'b0001_0000_0000,
    S_COPY_WR  = 12'b0010_0000_0000,
    S_ROW_END  = 12'b0100_0000_0000,
    S_DONE     = 12'b1000_0000_0000
  } state_t;

  cfg_t cfg;

  state_t            state_r, state_nxt;
  logic [LA_W-1:0]   clr_r, clr_nxt;
  logic [LINE_W-1:0] row_r, row_nxt, end_r, end_nxt, open_r, open_nxt;
  logic [CW-1:0]     a_r, a_nxt, b_r, b_nxt, s2_r, s2_nxt;
  logic [CNT_W-1:0]  n_r, n_nxt, rd_r, rd_nxt, wr_r, wr_nxt, cur_r, cur_nxt;
  logic [CNT_W-1:0]  sp_r, sp_nxt, cp_r, cp_nxt;
  logic              ovf_r, ovf_nxt, had_r, had_nxt;
  logic              out_valid_r;
  logic [LINE_W-1:0] out_open_r;
  logic              out_cov_r, out_ovf_r;

  logic              span_we;
  logic [SA_W-1:0]   span_waddr, span_raddr;
  logic [2*CW-1:0]   span_wdata, span_rdata;
  logic              cnt_we;
  logic [LA_W-1:0]   cnt_waddr, cnt_raddr;
  logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;

  logic [LINE_W-1:0] used, bot_c;
  logic [CW-1:0]     in_a, in_b, s1, s2;
  logic              load_out;

  scb_cfg u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  scb_ram #(.DW(2*CW), .AW(SA_W)) u_span_ram (
    .clk, .we(span_we), .waddr(span_waddr), .wdata(span_wdata),
    .raddr(span_raddr), .rdata(span_rdata)
  );

  scb_ram #(.DW(CNT_W), .AW(LA_W)) u_cnt_ram (
    .clk, .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  assign used  = (cfg.screen_height < LINE_W'(LCAP)) ? cfg.screen_height : LINE_W'(LCAP);
  assign bot_c = (in_rect_bottom < used) ? in_rect_bottom : used;
  assign in_a  = CW'(in_rect_left);
  assign in_b  = CW'(in_rect_right);
  assign s1    = span_rdata[CW-1:0];
  assign s2    = span_rdata[2*CW-1:CW];
  assign in_ready = (state_r == S_IDLE);
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    row_nxt   = row_r;
    end_nxt   = end_r;
    open_nxt  = open_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    s2_nxt    = s2_r;
    n_nxt     = n_r;
    rd_nxt    = rd_r;
    wr_nxt    = wr_r;
    cur_nxt   = cur_r;
    sp_nxt    = sp_r;
    cp_nxt    = cp_r;
    ovf_nxt   = ovf_r;
    had_nxt   = had_r;
    span_we    = 1'b0;
    span_waddr = {ROW_W'(row_r), IDX_W'(wr_r)};
    span_wdata = span_rdata;
    span_raddr = {ROW_W'(row_r), IDX_W'(rd_r)};
    cnt_we     = 1'b0;
    cnt_waddr  = LA_W'(row_r);
    cnt_wdata  = cur_r;
    cnt_raddr  = LA_W'(row_r);
    unique case (state_r)
      S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        clr_nxt   = clr_r + LA_W'(1);
        if (clr_r == LA_W'(MAX_LINES - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          a_nxt   = in_a;
          b_nxt   = in_b;
          ovf_nxt = 1'b0;
          if (in_kind == KIND_REOPEN) begin
            row_nxt   = '0;
            end_nxt   = used;
            open_nxt  = used;
            state_nxt = (used == '0) ? S_DONE : S_REOPEN;
          end else if (in_a < in_b && in_rect_top < bot_c) begin
            row_nxt   = in_rect_top;
            end_nxt   = bot_c;
            state_nxt = S_ROW_RD;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_REOPEN: begin
        cnt_we     = 1'b1;
        cnt_wdata  = CNT_W'(1);
        span_we    = 1'b1;
        span_waddr = {ROW_W'(row_r), IDX_W'(0)};
        span_wdata = {CW'(cfg.screen_width), CW'(0)};
        row_nxt    = row_r + LINE_W'(1);
        if (row_nxt == end_r) begin
          state_nxt = S_DONE;
        end
      end
      S_ROW_RD: begin
        state_nxt = S_ROW_WAIT;
      end
      S_ROW_WAIT: begin
        n_nxt   = cnt_rdata;
        cur_nxt = cnt_rdata;
        had_nxt = (cnt_rdata != '0);
        rd_nxt  = '0;
        wr_nxt  = '0;
        sp_nxt  = '0;
        cp_nxt  = '0;
        state_nxt = (cnt_rdata == '0) ? S_ROW_END : S_SPAN_RD;
      end
      S_SPAN_RD: begin
        state_nxt = S_SPAN_PRC;
      end
      S_SPAN_PRC: begin
        rd_nxt = rd_r + CNT_W'(1);
        if (!(a_r < s2 && b_r > s1)) begin
          span_we = 1'b1;
          wr_nxt  = wr_r + CNT_W'(1);
        end else if (a_r > s1) begin
          // keep the head; a right piece past the rectangle goes to the scratch row if there is room
          span_we    = 1'b1;
          span_wdata = {a_r, s1};
          wr_nxt     = wr_r + CNT_W'(1);
          if (b_r < s2) begin
            if (cur_r < CNT_W'(MAX_SPANS)) begin
              s2_nxt  = s2;
              cur_nxt = cur_r + CNT_W'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
        end else if (b_r < s2) begin
          span_we    = 1'b1;
          span_wdata = {s2, b_r};
          wr_nxt     = wr_r + CNT_W'(1);
        end else begin
          cur_nxt = cur_r - CNT_W'(1);
        end
        if (a_r < s2 && b_r > s1 && a_r > s1 && b_r < s2 && cur_r < CNT_W'(MAX_SPANS)) begin
          state_nxt = S_SPLIT;
        end else if (rd_nxt != n_r) begin
          state_nxt = S_SPAN_RD;
        end else begin
          state_nxt = (sp_r != '0) ? S_COPY_RD : S_ROW_END;
        end
      end
      S_SPLIT: begin
        span_we    = 1'b1;
        span_waddr = {SCR_ROW, IDX_W'(sp_r)};
        span_wdata = {s2_r, b_r};
        sp_nxt     = sp_r + CNT_W'(1);
        if (rd_r != n_r) begin
          state_nxt = S_SPAN_RD;
        end else begin
          state_nxt = S_COPY_RD;
        end
      end
      S_COPY_RD: begin
        span_raddr = {SCR_ROW, IDX_W'(cp_r)};
        state_nxt  = S_COPY_WR;
      end
      S_COPY_WR: begin
        // right pieces land after the surviving spans
        span_we = 1'b1;
        wr_nxt  = wr_r + CNT_W'(1);
        cp_nxt  = cp_r + CNT_W'(1);
        state_nxt = (cp_nxt == sp_r) ? S_ROW_END : S_COPY_RD;
      end
      S_ROW_END: begin
        cnt_we  = 1'b1;
        if (had_r && cur_r == '0 && open_r != '0) begin
          open_nxt = open_r - LINE_W'(1);
        end
        row_nxt = row_r + LINE_W'(1);
        state_nxt = (row_nxt == end_r) ? S_DONE : S_ROW_RD;
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      open_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      open_r  <= open_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    end_r <= end_nxt;
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    s2_r  <= s2_nxt;
    n_r   <= n_nxt;
    rd_r  <= rd_nxt;
    wr_r  <= wr_nxt;
    cur_r <= cur_nxt;
    sp_r  <= sp_nxt;
    cp_r  <= cp_nxt;
    ovf_r <= ovf_nxt;
    had_r <= had_nxt;
    if (load_out) begin
      out_open_r <= open_r;
      out_cov_r  <= (open_r == '0);
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_open_lines    = out_open_r;
  assign out_all_covered   = out_cov_r;
  assign out_span_overflow = out_ovf_r;

  `SCB_ASSERT(a_wr_behind_rd, (state_r == S_SPAN_PRC) |-> (wr_r <= rd_r), "write overtook read")
  `SCB_ASSERT(a_cnt_cap, (state_r == S_ROW_END) |-> (cur_r <= CNT_W'(MAX_SPANS)), "count overrun")
  `SCB_ASSERT(a_open_falls, (state_r == S_ROW_END) |=> (open_r <= $past(open_r)), "open count rose on a rectangle")
  `SCB_ASSERT(a_no_take_busy, (state_r != S_IDLE) |-> !in_ready, "word taken while busy")
  `SCB_ASSERT_ALWAYS(a_reset_clear, !rst_n |=> (state_r == S_CLEAR), "reset did not start clearing")
endmodule
